// File: hdl/assert_macros.svh
// Assertion macros shared by the date adder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GDAD_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define GDAD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define GDAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define GDAD_ASSERT(label, clk, rst, expr)
`define GDAD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GDAD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/gdad_pkg.sv
// Shared types, constants and calendar functions of the date adder.
`default_nettype none
package gdad_pkg;

   localparam int YEAR_BITS_DEF   = 16;
   localparam int OFFSET_BITS_DEF = 17;
   localparam int MONTH_W         = 4;
   localparam int DAY_W           = 5;
   localparam int MOD25_W         = 5;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [MOD25_W-1:0] MOD25_TOP = 5'd24;

   // result of the year modulo 25 residue unit
   typedef struct packed {
      logic                 done;
      logic [MOD25_W-1:0]   rem;
   } mod_result_type;

   // leap test from the low four year bits and whether the year is a multiple of 25
   function automatic logic is_leap(input logic [3:0] low4, input logic mult25);
      logic res;
      res = (low4[1:0] == 2'd0) && (!mult25 || (low4 == 4'd0));
      return res;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd2: begin
            len = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

// File: hdl/gdad_mod25.sv
// Residue of a signed year modulo 25 by reciprocal multiplication, with registered steps.
`default_nettype none
module gdad_mod25 import gdad_pkg::*; #(
   parameter int YEAR_BITS = YEAR_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [YEAR_BITS-1:0] year,
   output mod_result_type            result
);

   localparam int PROD_W = 2 * YEAR_BITS + 1;
   localparam int SHIFT  = YEAR_BITS + 5;
   // floor(2^SHIFT / 25): the quotient estimate is at most one low
   localparam logic [PROD_W-1:0]  RECIP    = PROD_W'((64'd1 << SHIFT) / 64'd25);
   localparam logic [MOD25_W-1:0] SIGN_MOD = MOD25_W'((64'd1 << YEAR_BITS) % 64'd25);
   localparam logic [MOD25_W:0]   MODULUS  = 6'd25;

   logic                 load_ff, load_in;
   logic                 quot_ff, quot_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [YEAR_BITS-1:0] year_ff, year_in;
   logic [MOD25_W:0]     qlow_ff, qlow_in;
   logic [MOD25_W-1:0]   rem_ff, rem_in;
   logic [PROD_W-1:0]    prod;
   logic [MOD25_W:0]     diff;
   logic [MOD25_W-1:0]   fixed;

   assign prod = PROD_W'(year_ff) * RECIP;

   // the difference is below 50, so six low bits of year - 25 * quotient suffice
   assign diff = year_ff[MOD25_W:0] - qlow_ff * MODULUS;

   // a negative year reads 2^YEAR_BITS too high as unsigned; take that off the unsigned residue
   always_comb begin
      if (rem_ff >= SIGN_MOD) begin
         fixed = rem_ff - SIGN_MOD;
      end else begin
         fixed = MOD25_W'(MODULUS - 6'(SIGN_MOD) + 6'(rem_ff));
      end
   end

   always_comb begin
      load_in = start;
      quot_in = load_ff;
      done_in = quot_ff;
      neg_in  = neg_ff;
      year_in = year_ff;
      qlow_in = qlow_ff;
      rem_in  = rem_ff;
      if (start) begin
         neg_in  = year[YEAR_BITS-1];
         year_in = year;
      end
      if (load_ff) begin
         qlow_in = prod[SHIFT +: MOD25_W + 1];
      end
      if (quot_ff) begin
         rem_in = (diff >= MODULUS) ? MOD25_W'(diff - MODULUS) : diff[MOD25_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b0;
         quot_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         load_ff <= load_in;
         quot_ff <= quot_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      year_ff <= year_in;
      qlow_ff <= qlow_in;
      rem_ff  <= rem_in;
   end

   assign result.done = done_ff;
   assign result.rem  = neg_ff ? fixed : rem_ff;

endmodule
`default_nettype wire

// File: hdl/gregorian_date_add_days.sv
// Top level: adds a signed day count to a proleptic Gregorian date.
// From accept to result: the year is first reduced modulo 25, then the walk takes
// one step per whole year skipped and one per month, and the result is loaded once
// the result slot is free. No new word is taken while one is in flight.
// Reset: synchronous, active high; clears the sequencer and the result valid flag.
`default_nettype none
`include "assert_macros.svh"
module gregorian_date_add_days import gdad_pkg::*; #(
   parameter int YEAR_BITS   = YEAR_BITS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   // fields from bit 0: start_year, start_month, start_day, day_offset, zero pad
   input  wire logic [((YEAR_BITS + OFFSET_BITS + MONTH_W + DAY_W + 7) / 8) * 8 - 1:0]
                     req_tdata,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // fields from bit 0: result_year, result_month, result_day, year_overflow, zero pad
   output logic [((YEAR_BITS + MONTH_W + DAY_W + 1 + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready
);

   localparam int RSP_W = ((YEAR_BITS + MONTH_W + DAY_W + 1 + 7) / 8) * 8;
   localparam int YW    = YEAR_BITS + 1;     // one guard bit catches overflow
   localparam int RW    = OFFSET_BITS + 2;   // remaining days, signed
   localparam int DW    = 10;                // step size, signed
   localparam int M_LO  = YEAR_BITS;
   localparam int D_LO  = YEAR_BITS + MONTH_W;
   localparam int O_LO  = YEAR_BITS + MONTH_W + DAY_W;

   localparam logic signed [RW-1:0] YEAR_SPAN = RW'(366);
   localparam logic        [DW-1:0] BASE_YEAR = DW'(365);

   typedef enum logic [1:0] {ST_IDLE, ST_MOD, ST_RUN} state_type;

   state_type              state_ff, state_in;
   logic signed [YW-1:0]   year_ff, year_in;
   logic [MONTH_W-1:0]     mon_ff, mon_in;
   logic signed [RW-1:0]   rem_ff, rem_in;
   logic [MOD25_W-1:0]     c25_ff, c25_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   logic                   req_fire;
   logic                   out_free;
   mod_result_type         mod_res;

   logic [YEAR_BITS-1:0]   in_year;
   logic [MONTH_W-1:0]     in_month, in_month_sat;
   logic [DAY_W-1:0]       in_day;
   logic [OFFSET_BITS-1:0] in_offset;

   logic                   leap_y, leap_yp, leap_yn;
   logic [DAY_W-1:0]       len_cur;
   logic [MONTH_W-1:0]     mon_prev, mon_next;
   logic signed [DW-1:0]   delta;
   logic [MONTH_W-1:0]     step_mon;
   logic                   year_up, year_dn;
   logic                   walk_done;
   logic signed [RW-1:0]   rem_sum;
   logic                   ovf;

   assign in_year   = req_tdata[YEAR_BITS-1:0];
   assign in_month  = req_tdata[M_LO +: MONTH_W];
   assign in_day    = req_tdata[D_LO +: DAY_W];
   assign in_offset = req_tdata[O_LO +: OFFSET_BITS];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // clamp month codes that name no month
   always_comb begin
      in_month_sat = in_month;
      if (in_month == '0) begin
         in_month_sat = MONTH_JAN;
      end else if (in_month > MONTH_DEC) begin
         in_month_sat = MONTH_DEC;
      end
   end

   gdad_mod25 #(
      .YEAR_BITS (YEAR_BITS)
   ) u_mod25 (
      .clock  (clock),
      .reset  (reset),
      .start  (req_fire),
      .year   (in_year),
      .result (mod_res)
   );

   // leap flags for this year and its neighbors, from the low bits and the mod-25 counter
   assign leap_y  = is_leap(year_ff[3:0], c25_ff == '0);
   assign leap_yp = is_leap(year_ff[3:0] + 4'd1, c25_ff == MOD25_TOP);
   assign leap_yn = is_leap(year_ff[3:0] - 4'd1, c25_ff == MOD25_W'(1));

   assign len_cur  = month_len(mon_ff, leap_y);
   assign mon_prev = (mon_ff == MONTH_JAN) ? MONTH_DEC : mon_ff - MONTH_W'(1);
   assign mon_next = (mon_ff == MONTH_DEC) ? MONTH_JAN : mon_ff + MONTH_W'(1);

   // pick one step of the walk: a whole year when far off, else one month, or flag the walk done
   always_comb begin
      delta     = '0;
      step_mon  = mon_ff;
      year_up   = 1'b0;
      year_dn   = 1'b0;
      walk_done = 1'b0;
      if (rem_ff <= -YEAR_SPAN) begin
         // back one year to the same month
         delta   = $signed(BASE_YEAR + DW'((mon_ff > MONTH_FEB) ? leap_y : leap_yn));
         year_dn = 1'b1;
      end else if (rem_ff < 0) begin
         // borrow the previous month
         delta    = $signed(DW'(month_len(mon_prev, leap_y)));
         step_mon = mon_prev;
         year_dn  = (mon_ff == MONTH_JAN);
      end else if (rem_ff >= YEAR_SPAN) begin
         // forward one year to the same month
         delta   = -$signed(BASE_YEAR + DW'((mon_ff > MONTH_FEB) ? leap_yp : leap_y));
         year_up = 1'b1;
      end else if (rem_ff >= $signed(RW'(len_cur))) begin
         // carry out of this month
         delta    = -$signed(DW'(len_cur));
         step_mon = mon_next;
         year_up  = (mon_ff == MONTH_DEC);
      end else begin
         walk_done = 1'b1;
      end
   end

   // the one adder on the remaining days, shared by every kind of step
   assign rem_sum = rem_ff + RW'(delta);

   assign ovf = year_ff[YW-1] != year_ff[YW-2];

   always_comb begin
      state_in     = state_ff;
      year_in      = year_ff;
      mon_in       = mon_ff;
      rem_in       = rem_ff;
      c25_in       = c25_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // day counts from the first of the month
               year_in  = YW'($signed(in_year));
               mon_in   = in_month_sat;
               rem_in   = RW'($signed(in_offset)) + RW'(in_day) - RW'(1);
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_res.done) begin
               c25_in   = mod_res.rem;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (walk_done) begin
               // hold until the result slot is free
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = RSP_W'({ovf, DAY_W'(rem_ff) + DAY_W'(1), mon_ff,
                                         year_ff[YEAR_BITS-1:0]});
                  state_in     = ST_IDLE;
               end
            end else begin
               rem_in = rem_sum;
               mon_in = step_mon;
               if (year_up) begin
                  year_in = year_ff + YW'(1);
                  c25_in  = (c25_ff == MOD25_TOP) ? '0 : c25_ff + MOD25_W'(1);
               end else if (year_dn) begin
                  year_in = year_ff - YW'(1);
                  c25_in  = (c25_ff == '0) ? MOD25_TOP : c25_ff - MOD25_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      year_ff     <= year_in;
      mon_ff      <= mon_in;
      rem_ff      <= rem_in;
      c25_ff      <= c25_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `GDAD_ASSERT_IMPL(a_month_range, clock, reset, state_ff == ST_RUN, mon_ff >= MONTH_JAN && mon_ff <= MONTH_DEC)
   `GDAD_ASSERT_IMPL(a_c25_range, clock, reset, state_ff == ST_RUN, c25_ff <= MOD25_TOP)
   `GDAD_ASSERT_IMPL(a_day_nonzero, clock, reset, rsp_valid_ff, rsp_data_ff[D_LO +: DAY_W] != '0)
   `GDAD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready)
   `GDAD_ASSERT_IMPL(a_done_in_range, clock, reset, state_ff == ST_RUN && walk_done, rem_ff < $signed(RW'(len_cur)))

endmodule
`default_nettype wire
